@@ hw/rtl/rmdr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmdr_pkg: shared types for the rescale block
// Mode codes, the queue word between front and back, and the pipe widths.
// ----------------------------------------------------------------------------
package rmdr_pkg;

    localparam int unsigned PROD_W = 128;
    localparam int unsigned DIV_W  = 64;

    typedef enum logic [2:0] {
        MODE_ZERO = 3'd0,
        MODE_AWAY = 3'd1,
        MODE_DOWN = 3'd2,
        MODE_UP   = 3'd3,
        MODE_BAD4 = 3'd4,
        MODE_NEAR = 3'd5,
        MODE_BAD6 = 3'd6,
        MODE_BAD7 = 3'd7
    } round_mode_t;

    // classified job handed from the front part to the back part
    typedef struct packed {
        logic [63:0] mag;
        logic [63:0] mult;
        logic [63:0] div;
        logic [63:0] offs;
        logic        neg;
        logic        bad;
    } job_t;

    // word moving down the divider pipe
    typedef struct packed {
        logic [127:0] num;
        logic [63:0]  rem;
        logic [63:0]  div;
        logic         neg;
        logic         bad;
    } stage_t;

endpackage

@@ hw/rtl/rmdr_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmdr_front: operand check and classification
// Validates operands, takes the magnitude, picks the rounding offset.
// ----------------------------------------------------------------------------
module rmdr_front (
    input  logic [63:0]     multiplicand,
    input  logic [63:0]     multiplier,
    input  logic [63:0]     divisor,
    input  logic [2:0]      round_mode,
    output rmdr_pkg::job_t  job
);
    import rmdr_pkg::*;

    round_mode_t mode;
    round_mode_t mode_eff;
    logic        neg;

    always_comb begin
        mode     = round_mode_t'(round_mode);
        neg      = multiplicand[63];
        mode_eff = mode;
        if (neg && (mode == MODE_DOWN)) begin
            mode_eff = MODE_UP;
        end else if (neg && (mode == MODE_UP)) begin
            mode_eff = MODE_DOWN;
        end
        job.neg  = neg;
        job.mult = multiplier;
        job.div  = divisor;
        job.bad  = (divisor == 64'd0) || divisor[63] || multiplier[63]
                || (mode == MODE_BAD4) || (mode == MODE_BAD6) || (mode == MODE_BAD7);
        if (!neg) begin
            job.mag = multiplicand;
        end else if (multiplicand == {1'b1, 63'd0}) begin
            job.mag = {1'b0, {63{1'b1}}};
        end else begin
            job.mag = 64'd0 - multiplicand;
        end
        case (mode_eff)
            MODE_NEAR: job.offs = {1'b0, divisor[63:1]};
            MODE_AWAY,
            MODE_UP:   job.offs = divisor - 64'd1;
            default:   job.offs = 64'd0;
        endcase
    end

endmodule

@@ hw/rtl/rmdr_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmdr_queue: two-entry job queue
// Decouples the front part from the back pipe.
// ----------------------------------------------------------------------------
module rmdr_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  rmdr_pkg::job_t  in_job,
    output logic            out_valid,
    input  logic            out_ready,
    output rmdr_pkg::job_t  out_job
);
    import rmdr_pkg::*;

    job_t       mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_job   = mem_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= in_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("queue count out of range");
    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 |-> !in_ready) else $error("full queue took a push");
    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0 && !push) |=> cnt_reg == 2'd0) else $error("count rose");

endmodule

@@ hw/rtl/rmdr_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmdr_back: multiply and restoring-divide pipe
// Four 32x32 partial products over two stages, then one quotient bit per
// stage for 128 stages, then sign fix and an output register.
// ----------------------------------------------------------------------------
module rmdr_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  rmdr_pkg::job_t  in_job,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [63:0]     quotient,
    output logic            bad_operand,
    output logic            overflow
);
    import rmdr_pkg::*;

    localparam int unsigned NST = PROD_W;

    logic advance;

    // multiply stage 1: partial products
    logic        v1_reg;
    logic [63:0] p00_reg, p01_reg, p10_reg, p11_reg, offs1_reg, div1_reg;
    logic        neg1_reg, bad1_reg;
    // multiply stage 2: summed product plus offset
    logic        v2_reg;
    stage_t      s2_reg;
    // divider pipe
    logic        v_reg [NST];
    stage_t      s_reg [NST];
    stage_t      s_in [NST];
    stage_t      s_next [NST];
    // output
    logic        vo_reg;
    logic [63:0] q_reg;
    logic        bad_reg, ovf_reg;

    logic [127:0] prod;
    logic [63:0]  qlo, qhi;

    // whole pipe moves together; stalls only when output is held
    assign advance   = !vo_reg || out_ready;
    assign in_ready  = advance;
    assign out_valid = vo_reg;
    assign quotient  = q_reg;
    assign bad_operand = bad_reg;
    assign overflow  = ovf_reg;

    assign qhi = s_reg[NST-1].num[127:64];
    assign qlo = s_reg[NST-1].num[63:0];

    always_comb begin
        prod = {p11_reg, 64'd0} + {32'd0, p01_reg, 32'd0} + {32'd0, p10_reg, 32'd0}
             + {64'd0, p00_reg} + {64'd0, offs1_reg};
    end

    // stage inputs: product register feeds the first divide stage
    always_comb begin
        s_in[0] = s2_reg;
        for (int i = 1; i < NST; i++) begin
            s_in[i] = s_reg[i-1];
        end
    end

    always_comb begin
        for (int i = 0; i < NST; i++) begin
            stage_t src;
            logic [64:0] trial;
            src = s_in[i];
            trial = {src.rem, src.num[127]};
            s_next[i] = src;
            s_next[i].num = {src.num[126:0], 1'b0};
            if (trial >= {1'b0, src.div}) begin
                trial = trial - {1'b0, src.div};
                s_next[i].num[0] = 1'b1;
            end
            s_next[i].rem = trial[63:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            p00_reg   <= {32'd0, in_job.mag[31:0]}  * {32'd0, in_job.mult[31:0]};
            p01_reg   <= {32'd0, in_job.mag[31:0]}  * {32'd0, in_job.mult[63:32]};
            p10_reg   <= {32'd0, in_job.mag[63:32]} * {32'd0, in_job.mult[31:0]};
            p11_reg   <= {32'd0, in_job.mag[63:32]} * {32'd0, in_job.mult[63:32]};
            offs1_reg <= in_job.offs;
            div1_reg  <= in_job.div;
            neg1_reg  <= in_job.neg;
            bad1_reg  <= in_job.bad;
            s2_reg.num <= prod;
            s2_reg.rem <= 64'd0;
            s2_reg.div <= bad1_reg ? 64'd1 : div1_reg;
            s2_reg.neg <= neg1_reg;
            s2_reg.bad <= bad1_reg;
            for (int i = 0; i < NST; i++) begin
                s_reg[i] <= s_next[i];
            end
            if (s_reg[NST-1].bad) begin
                q_reg   <= {1'b1, 63'd0};
                bad_reg <= 1'b1;
                ovf_reg <= 1'b0;
            end else if (s_reg[NST-1].neg) begin
                q_reg   <= 64'd0 - qlo;
                bad_reg <= 1'b0;
                ovf_reg <= (qhi != 64'd0) || (qlo > {1'b1, 63'd0});
            end else begin
                q_reg   <= qlo;
                bad_reg <= 1'b0;
                ovf_reg <= (qhi != 64'd0) || qlo[63];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vo_reg <= 1'b0;
            for (int i = 0; i < NST; i++) v_reg[i] <= 1'b0;
        end else if (advance) begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            v_reg[0] <= v2_reg;
            for (int i = 1; i < NST; i++) v_reg[i] <= v_reg[i-1];
            vo_reg   <= v_reg[NST-1];
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (vo_reg && !out_ready) |=> vo_reg && $stable(q_reg)) else $error("result lost");
    a_bad_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (vo_reg && bad_reg) |-> (q_reg == {1'b1, 63'd0}) && !ovf_reg)
        else $error("bad operand result wrong");
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        vo_reg |-> !(bad_reg && ovf_reg)) else $error("both flags set");

endmodule

@@ hw/rtl/rescale_mul_div_round.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rescale_mul_div_round: rounded a*b/c with 128-bit product
// Front check, two-entry queue, multiply and bit-per-stage divide pipe.
// ----------------------------------------------------------------------------
// Path: input word to output word through the queue register, 2 multiply
//   stages, 128 divide stages and 1 output register.
// Throughput: one word per cycle; the 128-stage divider takes a new quotient
//   every cycle and stalls as a whole only while output waits on m_tready.
// Reset: aresetn low clears all valid bits and the queue; data is not reset.
// ----------------------------------------------------------------------------
module rescale_mul_div_round (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [63:0] multiplicand, [127:64] multiplier, [191:128] divisor,
    // [194:192] round_mode, [199:195] zero
    input  logic [199:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [63:0] quotient, [64] bad_operand, [65] overflow, [71:66] zero
    output logic [71:0]  m_tdata
);
    import rmdr_pkg::*;

    job_t        f_job, q_job;
    logic        q_valid, q_ready;
    logic [63:0] quo;
    logic        bad, ovf;

    // classify the incoming word combinationally into the queue
    rmdr_front u_front (
        .multiplicand (s_tdata[63:0]),
        .multiplier   (s_tdata[127:64]),
        .divisor      (s_tdata[191:128]),
        .round_mode   (s_tdata[194:192]),
        .job          (f_job)
    );

    rmdr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_job    (f_job),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_job   (q_job)
    );

    rmdr_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (q_valid),
        .in_ready    (q_ready),
        .in_job      (q_job),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .quotient    (quo),
        .bad_operand (bad),
        .overflow    (ovf)
    );

    assign m_tdata = {6'd0, ovf, bad, quo};

endmodule
